[hw/rtl/psa_pkg.sv]
package psa_pkg;

   localparam int MAX_SPAN_PAGES = 128;
   localparam int POOL_PAGES     = 4096;

   localparam int PAGE_W   = $clog2(POOL_PAGES);
   localparam int LEN_W    = $clog2(MAX_SPAN_PAGES + 1);
   localparam int LINK_W   = PAGE_W + 1;
   localparam int CP_W     = $clog2(POOL_PAGES + 1);
   localparam int HEAD_NUM = MAX_SPAN_PAGES + 1;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   typedef logic [REQ_DATA_W-1:0] req_data_type;
   typedef logic [RSP_DATA_W-1:0] rsp_data_type;
   typedef logic [1:0]            kind_type;
   typedef logic [1:0]            status_type;

   localparam kind_type KIND_ALLOC  = 2'd0;
   localparam kind_type KIND_FREE   = 2'd1;
   localparam kind_type KIND_LOOKUP = 2'd2;
   localparam kind_type KIND_RSVD   = 2'd3;

   localparam status_type ST_OK       = 2'd0;
   localparam status_type ST_EXHAUST  = 2'd1;
   localparam status_type ST_BAD_SIZE = 2'd2;
   localparam status_type ST_BAD_SPAN = 2'd3;

   // link word: top bit set means no entry
   localparam logic [LINK_W-1:0] LINK_NIL = {1'b1, {PAGE_W{1'b0}}};

endpackage

[hw/rtl/page_span_allocator_unit.sv]
// Allocate scans size classes upward from the request size, may carve a fresh chunk or
//   split off a remainder, then stamps each granted page; free merges free neighbours
//   below and above; lookup reads the page map. Bad size, bad free, unknown kind and an
//   exhausted pool each give an error response. One request at a time: the next can be
//   accepted in the cycle after the response loads; a held response stalls it.
// Reset: synchronous; the page map then clears all 4096 entries, one entry a cycle, req_tready low.
module page_span_allocator_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  psa_pkg::req_data_type req_tdata,   // [7:0] page_count, [19:8] page_number
   input  psa_pkg::kind_type     req_tuser,   // [1:0] kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output psa_pkg::rsp_data_type rsp_tdata,   // [11:0] span_start, [19:12] span_pages
   output psa_pkg::status_type   rsp_tuser    // [1:0] status
);
   import psa_pkg::*;

   typedef enum logic [27:0] {
      S_CLR      = 28'd1 << 0,
      S_IDLE     = 28'd1 << 1,
      S_A_CHK    = 28'd1 << 2,
      S_A_SCAN   = 28'd1 << 3,
      S_A_HEAD   = 28'd1 << 4,
      S_A_CARVED = 28'd1 << 5,
      S_A_SPLIT  = 28'd1 << 6,
      S_A_MARK   = 28'd1 << 7,
      S_A_OWN    = 28'd1 << 8,
      S_F_CHK    = 28'd1 << 9,
      S_F_CHK2   = 28'd1 << 10,
      S_F_B      = 28'd1 << 11,
      S_F_B2     = 28'd1 << 12,
      S_F_B3     = 28'd1 << 13,
      S_F_F      = 28'd1 << 14,
      S_F_F2     = 28'd1 << 15,
      S_F_DONE   = 28'd1 << 16,
      S_L_RD     = 28'd1 << 17,
      S_L_CHK    = 28'd1 << 18,
      S_L_CHK2   = 28'd1 << 19,
      S_ER_RD    = 28'd1 << 20,
      S_ER_WR    = 28'd1 << 21,
      S_MF1      = 28'd1 << 22,
      S_MF2      = 28'd1 << 23,
      S_PU_RD    = 28'd1 << 24,
      S_PU_WR    = 28'd1 << 25,
      S_PU_WR2   = 28'd1 << 26,
      S_OUT      = 28'd1 << 27
   } state_type;

   // memories: page map, span length, in-use flag, list links, list heads
   logic [LINK_W-1:0] own_mem  [POOL_PAGES];
   logic [LEN_W-1:0]  len_mem  [POOL_PAGES];
   logic              use_mem  [POOL_PAGES];
   logic [LINK_W-1:0] nxt_mem  [POOL_PAGES];
   logic [LINK_W-1:0] prv_mem  [POOL_PAGES];
   logic [LINK_W-1:0] head_mem [HEAD_NUM];

   logic              own_we, len_we, use_we, nxt_we, prv_we, head_we;
   logic [PAGE_W-1:0] own_wa, len_wa, use_wa, nxt_wa, prv_wa;
   logic [PAGE_W-1:0] own_ra, len_ra, use_ra, nxt_ra, prv_ra;
   logic [LEN_W-1:0]  head_wa, head_ra;
   logic [LINK_W-1:0] own_wd, nxt_wd, prv_wd, head_wd;
   logic [LEN_W-1:0]  len_wd;
   logic              use_wd;
   logic [LINK_W-1:0] own_rd, nxt_rd, prv_rd, head_rd;
   logic [LEN_W-1:0]  len_rd;
   logic              use_rd;

   state_type          st_ff, st_in, ret_ff, ret_in;
   logic [LEN_W-1:0]   k_ff, k_in, len_ff, len_in, j_ff, j_in, i_ff, i_in;
   logic [LEN_W-1:0]   arg_l_ff, arg_l_in;
   logic [PAGE_W-1:0]  p_ff, p_in, s_ff, s_in, start_ff, start_in, arg_s_ff, arg_s_in;
   logic [PAGE_W-1:0]  clr_ff, clr_in;
   logic [CP_W-1:0]    cp_ff, cp_in;
   logic [LINK_W-1:0]  link_ff, link_in;
   logic [HEAD_NUM-1:0] head_ne_ff, head_ne_in;
   status_type         res_status_ff, res_status_in;
   logic [PAGE_W-1:0]  res_start_ff, res_start_in;
   logic [LEN_W-1:0]   res_pages_ff, res_pages_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [PAGE_W-1:0]  rsp_start_ff, rsp_start_in;
   logic [LEN_W-1:0]   rsp_pages_ff, rsp_pages_in;

   always_ff @(posedge clock) begin
      if (own_we) own_mem[own_wa] <= own_wd;
      own_rd <= own_mem[own_ra];
   end
   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_wa] <= len_wd;
      len_rd <= len_mem[len_ra];
   end
   always_ff @(posedge clock) begin
      if (use_we) use_mem[use_wa] <= use_wd;
      use_rd <= use_mem[use_ra];
   end
   always_ff @(posedge clock) begin
      if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
      nxt_rd <= nxt_mem[nxt_ra];
   end
   always_ff @(posedge clock) begin
      if (prv_we) prv_mem[prv_wa] <= prv_wd;
      prv_rd <= prv_mem[prv_ra];
   end
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd <= head_mem[head_ra];
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - PAGE_W - LEN_W){1'b0}}, rsp_pages_ff, rsp_start_ff};

   always_comb begin
      logic [CP_W-1:0]   nx;
      logic [CP_W-1:0]   sum_s;
      logic [LEN_W:0]    sum_l;
      logic [LINK_W-1:0] h;

      st_in = st_ff;           ret_in = ret_ff;
      k_in = k_ff;             p_in = p_ff;
      s_in = s_ff;             start_in = start_ff; len_in = len_ff;
      j_in = j_ff;             i_in = i_ff;       cp_in = cp_ff;
      arg_s_in = arg_s_ff;     arg_l_in = arg_l_ff; link_in = link_ff;
      clr_in = clr_ff;         head_ne_in = head_ne_ff;
      res_status_in = res_status_ff;
      res_start_in = res_start_ff;
      res_pages_in = res_pages_ff;

      own_we = 1'b0; own_wa = '0; own_wd = '0; own_ra = '0;
      len_we = 1'b0; len_wa = '0; len_wd = '0; len_ra = '0;
      use_we = 1'b0; use_wa = '0; use_wd = 1'b0; use_ra = '0;
      nxt_we = 1'b0; nxt_wa = '0; nxt_wd = '0; nxt_ra = '0;
      prv_we = 1'b0; prv_wa = '0; prv_wd = '0; prv_ra = '0;
      head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;

      nx    = {1'b0, start_ff} + CP_W'(len_ff);
      sum_s = {1'b0, s_ff} + CP_W'(len_rd);
      sum_l = {1'b0, len_ff} + {1'b0, len_rd};
      h     = head_ne_ff[arg_l_ff] ? head_rd : LINK_NIL;

      case (st_ff)
         S_CLR: begin
            // invalidate the page map one entry a cycle
            own_we = 1'b1;
            own_wa = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == PAGE_W'(POOL_PAGES - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               k_in    = req_tdata[LEN_W-1:0];
               p_in    = req_tdata[LEN_W +: PAGE_W];
               case (req_tuser)
                  KIND_ALLOC:  st_in = S_A_CHK;
                  KIND_FREE:   st_in = S_F_CHK;
                  KIND_LOOKUP: st_in = S_L_RD;
                  default: begin
                     res_status_in = ST_BAD_SPAN;
                     res_start_in  = '0;
                     res_pages_in  = '0;
                     st_in         = S_OUT;
                  end
               endcase
            end
         end
         S_A_CHK: begin
            if (k_ff == '0 || k_ff > LEN_W'(MAX_SPAN_PAGES)) begin
               res_status_in = ST_BAD_SIZE;
               res_start_in  = '0;
               res_pages_in  = '0;
               st_in         = S_OUT;
            end else begin
               j_in  = k_ff;
               st_in = S_A_SCAN;
            end
         end
         S_A_SCAN: begin
            // walk size classes upward until a non-empty list turns up; past the top, carve from the pool
            if (head_ne_ff[j_ff]) begin
               head_ra = j_ff;
               st_in   = S_A_HEAD;
            end else if (j_ff == LEN_W'(MAX_SPAN_PAGES)) begin
               if (cp_ff > CP_W'(POOL_PAGES - MAX_SPAN_PAGES)) begin
                  res_status_in = ST_EXHAUST;
                  res_start_in  = '0;
                  res_pages_in  = '0;
                  st_in         = S_OUT;
               end else begin
                  s_in     = cp_ff[PAGE_W-1:0];
                  arg_s_in = cp_ff[PAGE_W-1:0];
                  arg_l_in = LEN_W'(MAX_SPAN_PAGES);
                  cp_in    = cp_ff + CP_W'(MAX_SPAN_PAGES);
                  ret_in   = S_A_CARVED;
                  st_in    = S_MF1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_A_HEAD: begin
            s_in     = head_rd[PAGE_W-1:0];
            arg_s_in = head_rd[PAGE_W-1:0];
            arg_l_in = j_ff;
            ret_in   = S_A_SPLIT;
            st_in    = S_ER_RD;
         end
         S_A_CARVED: begin
            arg_s_in = s_ff;
            arg_l_in = j_ff;
            ret_in   = S_A_SPLIT;
            st_in    = S_ER_RD;
         end
         S_A_SPLIT: begin
            if (j_ff > k_ff) begin
               arg_s_in = s_ff + PAGE_W'(k_ff);
               arg_l_in = j_ff - k_ff;
               ret_in   = S_A_MARK;
               st_in    = S_MF1;
            end else begin
               st_in = S_A_MARK;
            end
         end
         S_A_MARK: begin
            len_we = 1'b1; len_wa = s_ff; len_wd = k_ff;
            use_we = 1'b1; use_wa = s_ff; use_wd = 1'b1;
            i_in   = '0;
            st_in  = S_A_OWN;
         end
         S_A_OWN: begin
            // stamp every page of the new span with its start
            own_we = 1'b1;
            own_wa = s_ff + PAGE_W'(i_ff);
            own_wd = {1'b1, s_ff};
            i_in   = i_ff + 1'b1;
            if (i_ff == k_ff - 1'b1) begin
               res_status_in = ST_OK;
               res_start_in  = s_ff;
               res_pages_in  = k_ff;
               st_in         = S_OUT;
            end
         end
         S_F_CHK: begin
            own_ra = p_ff; use_ra = p_ff; len_ra = p_ff;
            st_in  = S_F_CHK2;
         end
         S_F_CHK2: begin
            if (own_rd != {1'b1, p_ff} || !use_rd || len_rd == '0 ||
                len_rd > LEN_W'(MAX_SPAN_PAGES)) begin
               res_status_in = ST_BAD_SPAN;
               res_start_in  = '0;
               res_pages_in  = '0;
               st_in         = S_OUT;
            end else begin
               use_we   = 1'b1; use_wa = p_ff; use_wd = 1'b0;
               start_in = p_ff;
               len_in   = len_rd;
               st_in    = S_F_B;
            end
         end
         S_F_B: begin
            if (start_ff == '0) begin
               st_in = S_F_F;
            end else begin
               own_ra = start_ff - 1'b1;
               st_in  = S_F_B2;
            end
         end
         S_F_B2: begin
            if (!own_rd[PAGE_W]) begin
               st_in = S_F_F;
            end else begin
               s_in   = own_rd[PAGE_W-1:0];
               use_ra = own_rd[PAGE_W-1:0];
               len_ra = own_rd[PAGE_W-1:0];
               st_in  = S_F_B3;
            end
         end
         S_F_B3: begin
            // merge the free neighbor below while the total stays in range
            if (use_rd || sum_s != {1'b0, start_ff} || len_rd == '0 ||
                sum_l > (LEN_W+1)'(MAX_SPAN_PAGES)) begin
               st_in = S_F_F;
            end else begin
               arg_s_in = s_ff;
               arg_l_in = len_rd;
               len_in   = sum_l[LEN_W-1:0];
               start_in = s_ff;
               ret_in   = S_F_B;
               st_in    = S_ER_RD;
            end
         end
         S_F_F: begin
            if (nx >= CP_W'(POOL_PAGES)) begin
               st_in = S_F_DONE;
            end else begin
               own_ra = nx[PAGE_W-1:0];
               use_ra = nx[PAGE_W-1:0];
               len_ra = nx[PAGE_W-1:0];
               st_in  = S_F_F2;
            end
         end
         S_F_F2: begin
            // merge the free neighbor above
            if (own_rd != {1'b1, nx[PAGE_W-1:0]} || use_rd || len_rd == '0 ||
                sum_l > (LEN_W+1)'(MAX_SPAN_PAGES)) begin
               st_in = S_F_DONE;
            end else begin
               arg_s_in = nx[PAGE_W-1:0];
               arg_l_in = len_rd;
               len_in   = sum_l[LEN_W-1:0];
               ret_in   = S_F_F;
               st_in    = S_ER_RD;
            end
         end
         S_F_DONE: begin
            res_status_in = ST_OK;
            res_start_in  = start_ff;
            res_pages_in  = len_ff;
            arg_s_in      = start_ff;
            arg_l_in      = len_ff;
            ret_in        = S_OUT;
            st_in         = S_MF1;
         end
         S_L_RD: begin
            own_ra = p_ff;
            st_in  = S_L_CHK;
         end
         S_L_CHK: begin
            if (!own_rd[PAGE_W]) begin
               res_status_in = ST_BAD_SPAN;
               res_start_in  = '0;
               res_pages_in  = '0;
               st_in         = S_OUT;
            end else begin
               s_in   = own_rd[PAGE_W-1:0];
               use_ra = own_rd[PAGE_W-1:0];
               len_ra = own_rd[PAGE_W-1:0];
               st_in  = S_L_CHK2;
            end
         end
         S_L_CHK2: begin
            if (!use_rd || p_ff < s_ff || (p_ff - s_ff) >= PAGE_W'(len_rd)) begin
               res_status_in = ST_BAD_SPAN;
               res_start_in  = '0;
               res_pages_in  = '0;
            end else begin
               res_status_in = ST_OK;
               res_start_in  = s_ff;
               res_pages_in  = len_rd;
            end
            st_in = S_OUT;
         end
         S_ER_RD: begin
            prv_ra = arg_s_ff;
            nxt_ra = arg_s_ff;
            st_in  = S_ER_WR;
         end
         S_ER_WR: begin
            // unlink: patch predecessor (or head) and successor
            if (!prv_rd[PAGE_W]) begin
               nxt_we = 1'b1; nxt_wa = prv_rd[PAGE_W-1:0]; nxt_wd = nxt_rd;
            end else begin
               head_we = 1'b1; head_wa = arg_l_ff; head_wd = nxt_rd;
               head_ne_in[arg_l_ff] = !nxt_rd[PAGE_W];
            end
            if (!nxt_rd[PAGE_W]) begin
               prv_we = 1'b1; prv_wa = nxt_rd[PAGE_W-1:0]; prv_wd = prv_rd;
            end
            st_in = ret_ff;
         end
         S_MF1: begin
            len_we = 1'b1; len_wa = arg_s_ff; len_wd = arg_l_ff;
            use_we = 1'b1; use_wa = arg_s_ff; use_wd = 1'b0;
            own_we = 1'b1; own_wa = arg_s_ff; own_wd = {1'b1, arg_s_ff};
            st_in  = S_MF2;
         end
         S_MF2: begin
            own_we = 1'b1;
            own_wa = arg_s_ff + PAGE_W'(arg_l_ff) - 1'b1;
            own_wd = {1'b1, arg_s_ff};
            st_in  = S_PU_RD;
         end
         S_PU_RD: begin
            head_ra = arg_l_ff;
            st_in   = S_PU_WR;
         end
         S_PU_WR: begin
            nxt_we  = 1'b1; nxt_wa = arg_s_ff; nxt_wd = h;
            prv_we  = 1'b1; prv_wa = arg_s_ff; prv_wd = LINK_NIL;
            head_we = 1'b1; head_wa = arg_l_ff; head_wd = {1'b0, arg_s_ff};
            head_ne_in[arg_l_ff] = 1'b1;
            link_in = h;
            st_in   = S_PU_WR2;
         end
         S_PU_WR2: begin
            if (!link_ff[PAGE_W]) begin
               prv_we = 1'b1; prv_wa = link_ff[PAGE_W-1:0]; prv_wd = {1'b0, arg_s_ff};
            end
            st_in = ret_ff;
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // output register: hold until taken, load when the slot frees
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_pages_in  = rsp_pages_ff;
      if (st_ff == S_OUT && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tvalid_in = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_start_in  = res_start_ff;
         rsp_pages_in  = res_pages_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_CLR;
         ret_ff        <= S_IDLE;
         clr_ff        <= '0;
         cp_ff         <= '0;
         head_ne_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         st_ff         <= st_in;
         ret_ff        <= ret_in;
         clr_ff        <= clr_in;
         cp_ff         <= cp_in;
         head_ne_ff    <= head_ne_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      p_ff          <= p_in;
      s_ff          <= s_in;
      start_ff      <= start_in;
      len_ff        <= len_in;
      j_ff          <= j_in;
      i_ff          <= i_in;
      arg_s_ff      <= arg_s_in;
      arg_l_ff      <= arg_l_in;
      link_ff       <= link_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_pages_ff  <= res_pages_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_pages_ff  <= rsp_pages_in;
   end

   // one request in flight: no second accept right after one
   a_single: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second request accepted while busy");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ST_OK) |-> (rsp_tdata == '0))
      else $error("error response carries a span");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ST_OK) |->
      (rsp_pages_ff != '0 && rsp_pages_ff <= LEN_W'(MAX_SPAN_PAGES)))
      else $error("good response with bad length");

   a_carve: assert property (@(posedge clock) disable iff (reset)
      cp_ff <= CP_W'(POOL_PAGES))
      else $error("carve pointer past pool end");

endmodule
